[hdl/sdmc_pkg.sv]
// ----------------------------------------------------------------------------
// sdmc_pkg
// Shared types, register codes and helpers for the split direct-mapped
// cache lookup block.
// ----------------------------------------------------------------------------
package sdmc_pkg;

  localparam int unsigned MAX_LINES_DEF = 1024;
  localparam int unsigned LINE_W        = 10;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned GEOM_W        = 4;
  localparam int unsigned OUT_DATA_W    = 112;
  localparam int unsigned PADDR_W       = 4;

  localparam logic [GEOM_W-1:0] GEOM_MAX = 4'd10;

  // reset geometry
  localparam logic [GEOM_W-1:0] DATA_OFF_RST = 4'd5;
  localparam logic [GEOM_W-1:0] DATA_IDX_RST = 4'd10;
  localparam logic [GEOM_W-1:0] INST_OFF_RST = 4'd5;
  localparam logic [GEOM_W-1:0] INST_IDX_RST = 4'd10;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DATA_OFF = 2'd0;
  localparam logic [1:0] REG_DATA_IDX = 2'd1;
  localparam logic [1:0] REG_INST_OFF = 2'd2;
  localparam logic [1:0] REG_INST_IDX = 2'd3;

  // request kinds
  localparam logic [1:0] REQ_DATA_RD = 2'd0;
  localparam logic [1:0] REQ_DATA_WR = 2'd1;
  localparam logic [1:0] REQ_INST    = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  typedef struct packed {
    logic [GEOM_W-1:0] data_off;
    logic [GEOM_W-1:0] data_idx;
    logic [GEOM_W-1:0] inst_off;
    logic [GEOM_W-1:0] inst_idx;
  } geom_t;

  // classified word handed from front to back
  typedef struct packed {
    logic              is_inst;
    logic [LINE_W-1:0] line;
    logic [TAG_W-1:0]  tag;
  } item_t;

  function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v);
    clamp_geom = (v > GEOM_MAX) ? GEOM_MAX : v;
  endfunction

endpackage

[hdl/sdmc_front.sv]
// ----------------------------------------------------------------------------
// sdmc_front
// Accepts trace words, drops the null request, splits the address into
// line index and tag, and reduces the index to the line count.
// ----------------------------------------------------------------------------
module sdmc_front #(
  parameter int unsigned MAX_LINES = sdmc_pkg::MAX_LINES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sdmc_pkg::geom_t             geom_i,
  input  logic                        clearing_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  in_req_i,
  input  logic [sdmc_pkg::ADDR_W-1:0] in_addr_i,
  output logic                        push_o,
  input  logic                        full_i,
  output sdmc_pkg::item_t             item_o
);

  localparam int unsigned LW = sdmc_pkg::LINE_W;

  // stage 0: raw word
  logic                        s0_valid_q;
  logic [1:0]                  s0_req_q;
  logic [sdmc_pkg::ADDR_W-1:0] s0_addr_q;

  // stage 1: split address
  logic                        s1_valid_q;
  logic                        s1_inst_q;
  logic [LW-1:0]               s1_masked_q;
  logic [LW-1:0]               s1_quot_q;
  logic [sdmc_pkg::TAG_W-1:0]  s1_tag_q;

  logic                        s0_inst;
  logic                        s0_drop;
  logic                        s0_adv;
  logic                        s1_load;
  logic [sdmc_pkg::GEOM_W-1:0] off_bits;
  logic [sdmc_pkg::GEOM_W-1:0] idx_bits;
  logic [sdmc_pkg::ADDR_W-1:0] blk;
  logic [LW-1:0]               idx_mask;
  logic [LW-1:0]               masked;
  logic [sdmc_pkg::TAG_W-1:0]  tag;
  logic [LW-1:0]               quot;
  logic [LW-1:0]               line;

  assign s0_inst  = (s0_req_q == sdmc_pkg::REQ_INST);
  assign s0_drop  = (s0_req_q == sdmc_pkg::REQ_NONE);
  assign push_o   = s1_valid_q && !full_i;
  assign s1_load  = s0_valid_q && !s0_drop && (!s1_valid_q || push_o);
  assign s0_adv   = s0_valid_q && (s0_drop || !s1_valid_q || push_o);
  assign in_ready_o = !clearing_i && (!s0_valid_q || s0_adv);

  assign off_bits = sdmc_pkg::clamp_geom(s0_inst ? geom_i.inst_off : geom_i.data_off);
  assign idx_bits = sdmc_pkg::clamp_geom(s0_inst ? geom_i.inst_idx : geom_i.data_idx);
  assign blk      = s0_addr_q >> off_bits;
  assign idx_mask = ~({LW{1'b1}} << idx_bits);
  assign masked   = blk[LW-1:0] & idx_mask;
  assign tag      = blk >> idx_bits;

  // index modulo line count: reciprocal multiply here, back-multiply next stage
  if (MAX_LINES >= (1 << LW)) begin : g_nomod
    assign quot = '0;
    assign line = s1_masked_q;
  end else begin : g_mod
    localparam int unsigned RECIP_SH = 2 * LW;
    localparam int unsigned RECIP    = ((1 << RECIP_SH) + MAX_LINES - 1) / MAX_LINES;
    localparam logic [RECIP_SH:0] RECIP_K = (RECIP_SH + 1)'(RECIP);
    localparam logic [LW-1:0]     MOD_K   = LW'(MAX_LINES);
    logic [RECIP_SH+LW:0] prod;
    logic [2*LW-1:0]      back;
    assign prod = (RECIP_SH + LW + 1)'(masked) * (RECIP_SH + LW + 1)'(RECIP_K);
    assign quot = prod[RECIP_SH+LW-1:RECIP_SH];
    assign back = (2 * LW)'(s1_quot_q) * (2 * LW)'(MOD_K);
    assign line = s1_masked_q - back[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s0_valid_q <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_q <= 1'b0;
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_req_q  <= in_req_i;
      s0_addr_q <= in_addr_i;
    end
    if (s1_load) begin
      s1_inst_q   <= s0_inst;
      s1_masked_q <= masked;
      s1_quot_q   <= quot;
      s1_tag_q    <= tag;
    end
  end

  assign item_o.is_inst = s1_inst_q;
  assign item_o.line    = line;
  assign item_o.tag     = s1_tag_q;

endmodule

[hdl/sdmc_fifo.sv]
// ----------------------------------------------------------------------------
// sdmc_fifo
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sdmc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdmc_pkg::item_t din_i,
  output logic            full_o,
  input  logic            pop_i,
  output sdmc_pkg::item_t dout_o,
  output logic            empty_o
);

  sdmc_pkg::item_t entry_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign dout_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

[hdl/sdmc_back.sv]
// ----------------------------------------------------------------------------
// sdmc_back
// Tag stores, hit/miss decision, counters and the output register.
// Clears both tag stores once after reset.
// ----------------------------------------------------------------------------
module sdmc_back #(
  parameter int unsigned MAX_LINES = sdmc_pkg::MAX_LINES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            clearing_o,
  input  logic                            empty_i,
  input  sdmc_pkg::item_t                 item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sdmc_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_inst_o
);

  localparam int unsigned LINES  = (MAX_LINES < (1 << sdmc_pkg::LINE_W)) ?
                                   MAX_LINES : (1 << sdmc_pkg::LINE_W);
  localparam int unsigned MADDR_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [MADDR_W-1:0] LAST = MADDR_W'(LINES - 1);
  localparam int unsigned TW = sdmc_pkg::TAG_W;
  localparam int unsigned CW = sdmc_pkg::CNT_W;
  localparam int unsigned PAD_W = sdmc_pkg::OUT_DATA_W - 1 - sdmc_pkg::LINE_W - 3 * CW;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CMP   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [TW:0] dmem [LINES];
  logic [TW:0] imem [LINES];
  logic [TW:0] drd_q;
  logic [TW:0] ird_q;

  logic [MADDR_W-1:0] clr_cnt_q;
  sdmc_pkg::item_t    item_q;

  logic [CW-1:0] dacc_q, dhit_q, dmiss_q;
  logic [CW-1:0] iacc_q, ihit_q, imiss_q;

  logic                       out_valid_q;
  logic                       out_hit_q;
  logic                       out_inst_q;
  logic [sdmc_pkg::LINE_W-1:0] out_line_q;
  logic [CW-1:0]              out_acc_q, out_hits_q, out_miss_q;

  logic              in_cmp;
  logic [TW:0]       rd;
  logic              hit;
  logic              mem_we_d;
  logic              mem_we_i;
  logic [MADDR_W-1:0] waddr;
  logic [TW:0]       wdata;
  logic [MADDR_W-1:0] raddr;
  logic [CW-1:0]     sel_acc, sel_hit, sel_miss;

  assign clearing_o = (state_q == S_CLEAR);
  assign in_cmp     = (state_q == S_CMP);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // the result register is free by the time this word reaches compare
        if (!empty_i && (!out_valid_q || out_ready_i)) begin
          pop_o   = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign rd  = item_q.is_inst ? ird_q : drd_q;
  assign hit = rd[TW] && (rd[TW-1:0] == item_q.tag);

  assign raddr    = item_i.line[MADDR_W-1:0];
  assign waddr    = clearing_o ? clr_cnt_q : item_q.line[MADDR_W-1:0];
  assign wdata    = clearing_o ? '0 : {1'b1, item_q.tag};
  assign mem_we_d = clearing_o || (in_cmp && !hit && !item_q.is_inst);
  assign mem_we_i = clearing_o || (in_cmp && !hit && item_q.is_inst);

  always_ff @(posedge clk_i) begin
    if (mem_we_d) begin
      dmem[waddr] <= wdata;
    end
    if (pop_o) begin
      drd_q <= dmem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      imem[waddr] <= wdata;
    end
    if (pop_o) begin
      ird_q <= imem[raddr];
    end
  end

  assign sel_acc  = item_q.is_inst ? iacc_q  : dacc_q;
  assign sel_hit  = item_q.is_inst ? ihit_q  : dhit_q;
  assign sel_miss = item_q.is_inst ? imiss_q : dmiss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      dacc_q      <= '0;
      dhit_q      <= '0;
      dmiss_q     <= '0;
      iacc_q      <= '0;
      ihit_q      <= '0;
      imiss_q     <= '0;
    end else begin
      state_q <= state_d;
      if (clearing_o) begin
        clr_cnt_q <= clr_cnt_q + MADDR_W'(1);
      end
      if (in_cmp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_cmp) begin
        if (item_q.is_inst) begin
          iacc_q <= iacc_q + CW'(1);
          if (hit) begin
            ihit_q <= ihit_q + CW'(1);
          end else begin
            imiss_q <= imiss_q + CW'(1);
          end
        end else begin
          dacc_q <= dacc_q + CW'(1);
          if (hit) begin
            dhit_q <= dhit_q + CW'(1);
          end else begin
            dmiss_q <= dmiss_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (in_cmp) begin
      out_hit_q  <= hit;
      out_inst_q <= item_q.is_inst;
      out_line_q <= item_q.line;
      out_acc_q  <= sel_acc + CW'(1);
      out_hits_q <= sel_hit + CW'(hit);
      out_miss_q <= sel_miss + CW'(!hit);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_inst_o  = out_inst_q;
  assign out_data_o  = {{PAD_W{1'b0}}, out_miss_q, out_hits_q, out_acc_q,
                        out_line_q, out_hit_q};

endmodule

[hdl/split_direct_mapped_cache_lookup.sv]
// ----------------------------------------------------------------------------
// split_direct_mapped_cache_lookup
// Tag-only hit/miss model of a split direct-mapped data/instruction cache.
// ----------------------------------------------------------------------------
// Input stream: one word per trace access. tuser carries the request kind
// (0 data read, 1 data write, 2 instruction fetch, 3 null), tdata the byte
// address. A null request is taken and dropped without a result.
// Output stream: one word per real access with hit flag, line index and the
// access, hit and miss totals of the cache used, after this access.
// The APB port sets offset and index widths for each cache; write it only
// while the block is idle.
// Back end: a new access is taken only after the last one has left compare,
// as set by the read-then-compare sequence on the tag store port.
// Reset: both tag stores are cleared one line at a time over min(MAX_LINES,
// 1024) lines, and no input word is taken during that pass. Totals restart
// at zero.
// A stalled output holds its word; the front and its queue keep taking input
// until full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module split_direct_mapped_cache_lookup #(
  parameter int unsigned MAX_LINES = sdmc_pkg::MAX_LINES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdmc_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sdmc_pkg::ADDR_W-1:0]      s_axis_tdata,  // [31:0] byte_address
  input  logic [1:0]                       s_axis_tuser,  // [1:0] req_type
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] hit, [10:1] line_index, [42:11] access_count, [74:43] hit_count,
  // [106:75] miss_count, [111:107] zero
  output logic [sdmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser   // [0] from_inst_cache
);

  localparam int unsigned GW = sdmc_pkg::GEOM_W;

  sdmc_pkg::geom_t geom_q;
  sdmc_pkg::item_t front_item;
  sdmc_pkg::item_t fifo_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  logic            clearing;
  logic            cfg_we;
  logic [1:0]      reg_sel;
  logic [GW-1:0]   rd_val;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.data_off <= sdmc_pkg::DATA_OFF_RST;
      geom_q.data_idx <= sdmc_pkg::DATA_IDX_RST;
      geom_q.inst_off <= sdmc_pkg::INST_OFF_RST;
      geom_q.inst_idx <= sdmc_pkg::INST_IDX_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        sdmc_pkg::REG_DATA_OFF: geom_q.data_off <= pwdata[GW-1:0];
        sdmc_pkg::REG_DATA_IDX: geom_q.data_idx <= pwdata[GW-1:0];
        sdmc_pkg::REG_INST_OFF: geom_q.inst_off <= pwdata[GW-1:0];
        sdmc_pkg::REG_INST_IDX: geom_q.inst_idx <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sdmc_pkg::REG_DATA_OFF: rd_val = geom_q.data_off;
      sdmc_pkg::REG_DATA_IDX: rd_val = geom_q.data_idx;
      sdmc_pkg::REG_INST_OFF: rd_val = geom_q.inst_off;
      sdmc_pkg::REG_INST_IDX: rd_val = geom_q.inst_idx;
      default:                rd_val = '0;
    endcase
  end

  assign prdata = {{(32 - GW){1'b0}}, rd_val};

  sdmc_front #(
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom_q),
    .clearing_i (clearing),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (s_axis_tuser),
    .in_addr_i  (s_axis_tdata),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  sdmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (fifo_item),
    .empty_o (empty)
  );

  sdmc_back #(
    .MAX_LINES (MAX_LINES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .empty_i     (empty),
    .item_i      (fifo_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_inst_o  (m_axis_tuser)
  );

endmodule
